@@ hdl/bfiq_pkg.sv @@
// ----------------------------------------------------------------------------
// bfiq_pkg
// Shared types, sizes and helpers for the bloom filter insert/query unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bfiq_pkg;

	// Storage geometry
	localparam int MAX_BYTES = 8192;
	localparam int BYTE_W    = 8;
	localparam int ADDR_W    = $clog2(MAX_BYTES);
	localparam int POS_W     = ADDR_W + 3;
	localparam int EFF_W     = POS_W + 1;
	localparam int CAP_BITS  = MAX_BYTES * 8;

	// Register and field widths
	localparam int CFG_W      = 17;
	localparam int CNT_W      = 5;
	localparam int HASH_W     = 32;
	localparam int HASH_LIMIT = 30;
	localparam int MIN_BITS   = 64;
	localparam int ROT        = 17;

	// Remainder unit: a 33-bit dividend covers both the hash and 2^32
	localparam int DVD_W  = HASH_W + 1;
	localparam int STEP_W = $clog2(DVD_W + 1);

	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_QUERY  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [0:0] {
		REG_FILTER_BITS = 1'b0,
		REG_HASH_COUNT  = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_MOD_H,
		ST_MOD_D,
		ST_MOD_W,
		ST_RD,
		ST_CHK,
		ST_FIN
	} state_t;

	// Clamp to the minimum, round up to whole bytes, limit to capacity
	function automatic logic [EFF_W-1:0] eff_bits(input logic [CFG_W-1:0] fb);
		logic [CFG_W:0] lo;
		logic [CFG_W:0] rnd;
		lo  = (fb < CFG_W'(MIN_BITS)) ? (CFG_W+1)'(MIN_BITS) : {1'b0, fb};
		rnd = lo + (CFG_W+1)'(7);
		rnd = {rnd[CFG_W:3], 3'b000};
		if (rnd > (CFG_W+1)'(CAP_BITS)) begin
			return EFF_W'(CAP_BITS);
		end
		return EFF_W'(rnd);
	endfunction

endpackage

`default_nettype wire

@@ hdl/bfiq_ram.sv @@
// ----------------------------------------------------------------------------
// bfiq_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfiq_ram #(
	parameter int W = 8,
	parameter int D = 256
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] addr,
	input  wire logic [W-1:0]         wdata,
	output logic      [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];

	// Write at the address, register the read of the same address
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

@@ hdl/bfiq_mod_unit.sv @@
// ----------------------------------------------------------------------------
// bfiq_mod_unit
// Bit-serial restoring remainder: one dividend bit per cycle, done pulse at
// the end with the remainder held until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module bfiq_mod_unit
	import bfiq_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [EFF_W-1:0] divisor,
	output logic                  done,
	output logic      [POS_W-1:0] rem
);

	logic [DVD_W-1:0]  dvd_q;
	logic [POS_W-1:0]  rem_q;
	logic [EFF_W-1:0]  dsr_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [EFF_W-1:0]  part;
	logic [POS_W-1:0]  rem_next;

	// Shift in the next bit, subtract the divisor where it fits
	always_comb begin
		part = {rem_q, dvd_q[DVD_W-1]};
		if (part >= dsr_q) begin
			rem_next = POS_W'(part - dsr_q);
		end else begin
			rem_next = POS_W'(part);
		end
	end

	// Control: load on go, count down the dividend bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DVD_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

@@ hdl/bloom_filter_insert_query_unit.sv @@
// ----------------------------------------------------------------------------
// bloom_filter_insert_query_unit
// Bloom filter bit array with double-hashing probes: clear, insert, query.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                                  Dir  Notes
//  -------  ---------------------------------------  ---  ---------------------
//  in       in_valid, in_ready, action, key_hash     in   one beat per item
//  out      out_valid, out_ready, may_match          out  one beat per item
//  cfg      cfg_we, cfg_index, cfg_data              in   write only, no wait
//
//  After reset the array is swept to zero, one byte a cycle, with in_ready low.
//  A clear item sweeps the same way, then passes through the finish state.
//  Insert and query first take three serial remainders (hash, step, 2^32
//  modulo the filter size) in the remainder unit, then each probe reads the
//  memory byte and, for an insert, writes back the merged byte; a query stops
//  at the first clear bit. Items with no probes go straight to the finish state.
//  A result waits in the output register while the next item is accepted;
//  the next result is held back until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module bloom_filter_insert_query_unit
	import bfiq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        action,
	input  wire logic [HASH_W-1:0] key_hash,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   may_match,
	input  wire logic              cfg_we,
	input  wire logic [0:0]        cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data
);

	state_t            state_q, nstate;
	logic              go_q;
	action_t           act_q;
	logic [HASH_W-1:0] h_q;
	logic [HASH_W-1:0] dh_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  dmod_q;
	logic [POS_W-1:0]  wmod_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              match_q;
	logic              clr_item_q;
	logic [ADDR_W-1:0] sweep_q;
	logic [EFF_W-1:0]  eff_q;
	logic [CNT_W-1:0]  hcnt_q;
	logic              out_valid_q;
	logic              may_match_q;

	action_t           in_act;
	logic              in_beat;
	logic              fin_load;
	logic              mod_done;
	logic [POS_W-1:0]  mod_rem;
	logic [DVD_W-1:0]  mod_dvd;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [BYTE_W-1:0] ram_wdata;
	logic [BYTE_W-1:0] ram_rdata;
	logic              bit_hit;
	logic [BYTE_W-1:0] bit_mask;
	logic [HASH_W:0]   h_sum;
	logic [EFF_W-1:0]  p_sum;
	logic [POS_W-1:0]  p_red;
	logic [POS_W-1:0]  pos_next;

	assign in_act   = action_t'(action);
	assign in_ready = (state_q == ST_IDLE);
	assign in_beat  = in_valid && in_ready;
	assign fin_load = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	// Remainder unit: dividend chosen by the current setup state
	always_comb begin
		case (state_q)
			ST_MOD_H: mod_dvd = {1'b0, h_q};
			ST_MOD_D: mod_dvd = {1'b0, dh_q};
			default:  mod_dvd = {1'b1, HASH_W'(0)};
		endcase
	end

	bfiq_mod_unit u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go_q),
		.dividend (mod_dvd),
		.divisor  (eff_q),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// Probe bit and next probe position, kept below the filter size
	assign bit_hit  = ram_rdata[pos_q[2:0]];
	assign bit_mask = BYTE_W'(1) << pos_q[2:0];
	assign h_sum    = {1'b0, h_q} + {1'b0, dh_q};
	assign p_sum    = {1'b0, pos_q} + {1'b0, dmod_q};

	always_comb begin
		if (p_sum >= eff_q) begin
			p_red = POS_W'(p_sum - eff_q);
		end else begin
			p_red = POS_W'(p_sum);
		end
		// A wrap of the 32-bit hash removes 2^32 mod size
		if (!h_sum[HASH_W]) begin
			pos_next = p_red;
		end else if (p_red >= wmod_q) begin
			pos_next = p_red - wmod_q;
		end else begin
			pos_next = POS_W'({1'b0, p_red} + eff_q - {1'b0, wmod_q});
		end
	end

	// Memory port: sweep writes zeros, insert writes back the merged byte
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = pos_q[POS_W-1:3];
		ram_wdata = ram_rdata | bit_mask;
		if (state_q == ST_SWEEP) begin
			ram_we    = 1'b1;
			ram_addr  = sweep_q;
			ram_wdata = '0;
		end else if (state_q == ST_CHK && act_q == ACT_INSERT) begin
			ram_we = 1'b1;
		end
	end

	bfiq_ram #(
		.W (BYTE_W),
		.D (MAX_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Next state
	always_comb begin
		nstate = state_q;
		case (state_q)
			ST_SWEEP: begin
				if (sweep_q == '1) begin
					nstate = clr_item_q ? ST_FIN : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					case (in_act)
						ACT_CLEAR:  nstate = ST_SWEEP;
						ACT_INSERT: nstate = (hcnt_q == '0) ? ST_FIN : ST_MOD_H;
						ACT_QUERY: begin
							if (hcnt_q == '0 || hcnt_q > CNT_W'(HASH_LIMIT)) begin
								nstate = ST_FIN;
							end else begin
								nstate = ST_MOD_H;
							end
						end
						default:    nstate = ST_FIN;
					endcase
				end
			end
			ST_MOD_H: if (mod_done) nstate = ST_MOD_D;
			ST_MOD_D: if (mod_done) nstate = ST_MOD_W;
			ST_MOD_W: if (mod_done) nstate = ST_RD;
			ST_RD:    nstate = ST_CHK;
			ST_CHK: begin
				if ((act_q == ACT_QUERY && !bit_hit) || cnt_q == CNT_W'(1)) begin
					nstate = ST_FIN;
				end else begin
					nstate = ST_RD;
				end
			end
			ST_FIN:   if (fin_load) nstate = ST_IDLE;
			default:  nstate = ST_IDLE;
		endcase
	end

	// State register and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			go_q        <= 1'b0;
			clr_item_q  <= 1'b0;
			sweep_q     <= '0;
			eff_q       <= EFF_W'(MIN_BITS);
			hcnt_q      <= CNT_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= nstate;
			go_q    <= (nstate != state_q) &&
			           (nstate == ST_MOD_H || nstate == ST_MOD_D || nstate == ST_MOD_W);
			if (state_q == ST_SWEEP) begin
				sweep_q <= sweep_q + ADDR_W'(1);
			end
			if (in_beat) begin
				clr_item_q <= (in_act == ACT_CLEAR);
			end
			// Configuration writes
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_FILTER_BITS: eff_q  <= eff_bits(cfg_data);
					REG_HASH_COUNT:  hcnt_q <= cfg_data[CNT_W-1:0];
					default:         ;
				endcase
			end
			// Output register: load a result, drop it once taken
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item datapath
	always_ff @(posedge clk) begin
		if (in_beat) begin
			act_q   <= in_act;
			h_q     <= key_hash;
			dh_q    <= {key_hash[ROT-1:0], key_hash[HASH_W-1:ROT]};
			cnt_q   <= hcnt_q;
			match_q <= (in_act == ACT_QUERY);
		end
		if (mod_done) begin
			case (state_q)
				ST_MOD_H: pos_q  <= mod_rem;
				ST_MOD_D: dmod_q <= mod_rem;
				ST_MOD_W: wmod_q <= mod_rem;
				default:  ;
			endcase
		end
		// Advance to the next probe
		if (state_q == ST_CHK) begin
			if (act_q == ACT_QUERY && !bit_hit) begin
				match_q <= 1'b0;
			end
			pos_q <= pos_next;
			h_q   <= h_sum[HASH_W-1:0];
			cnt_q <= cnt_q - CNT_W'(1);
		end
		if (fin_load) begin
			may_match_q <= match_q;
		end
	end

	assign out_valid = out_valid_q;
	assign may_match = may_match_q;

	// Checks
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |-> (EFF_W'(pos_q) < eff_q))
		else $error("probe position not below filter size");

	a_probe_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD || state_q == ST_CHK) |-> (cnt_q != '0))
		else $error("probe with no probes left");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !in_ready)
		else $error("second item taken while one is at work");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_valid_q && !out_ready) |=> (state_q == ST_FIN))
		else $error("result overwrote a waiting one");

	a_sweep_no_item: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |-> (ram_we && !in_ready))
		else $error("sweep not writing or item open");

endmodule

`default_nettype wire
